/* design/clhq_pkg.sv */
`timescale 1ns / 1ps

package clhq_pkg;

    localparam int THREADS_DEF = 64;

    localparam int OP_W     = 2;
    localparam int THREAD_W = 6;

    localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_POLL    = 2'd2;

endpackage

/* design/clhq_node_mem.sv */
`timescale 1ns / 1ps

module clhq_node_mem #(
    parameter int THREADS = clhq_pkg::THREADS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rd_en,
    input  logic [$clog2(THREADS+1)-1:0]   rd_addr,
    output logic                           rd_done,
    output logic [$clog2(THREADS+1)-1:0]   rd_pred,
    input  logic                           wr_en,
    input  logic [$clog2(THREADS+1)-1:0]   wr_addr,
    input  logic                           wr_done,
    input  logic [$clog2(THREADS+1)-1:0]   wr_pred
);

    localparam int NODES = THREADS + 1;
    localparam int NW    = $clog2(NODES);

    logic [NW:0]      mem [NODES];
    logic [NW:0]      rd_data_reg;
    logic [NODES-1:0] written_reg;
    logic             rd_written_reg;

    // Read before write: a read of the entry being written returns the old value.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_done, wr_pred};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // An entry never written reads as its reset value: done set, predecessor zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_done = rd_written_reg ? rd_data_reg[NW]     : 1'b1;
    assign rd_pred = rd_written_reg ? rd_data_reg[NW-1:0] : '0;

endmodule

/* design/clhq_thread_mem.sv */
`timescale 1ns / 1ps

module clhq_thread_mem #(
    parameter int THREADS = clhq_pkg::THREADS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rd_en,
    input  logic [$clog2(THREADS)-1:0]     rd_addr,
    output logic [$clog2(THREADS+1)-1:0]   rd_node,
    input  logic                           wr_en,
    input  logic [$clog2(THREADS)-1:0]     wr_addr,
    input  logic [$clog2(THREADS+1)-1:0]   wr_node
);

    localparam int NW = $clog2(THREADS + 1);
    localparam int TW = $clog2(THREADS);

    logic [NW-1:0]      mem [THREADS];
    logic [NW-1:0]      rd_data_reg;
    logic [TW-1:0]      rd_addr_reg;
    logic [THREADS-1:0] written_reg;
    logic               rd_written_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_node;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // Until a thread releases for the first time it owns the node of its own number.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_node = rd_written_reg ? rd_data_reg : NW'(rd_addr_reg);

endmodule

/* design/clh_queue_lock_unit.sv */
// An acquire or release item passes through S_LOOKUP, S_NODE and S_EMIT, a poll adds S_PRED
// after S_NODE, and an item with an unused op or thread goes straight to S_EMIT.
// A new item is taken only in S_IDLE, once the last result has left S_EMIT;
// the chain of reads through the thread table and the node memory sets these steps.
// Reset is asynchronous and takes effect at once; per-entry written flags stand in
// for the memory contents, so no clearing pass follows reset.
`timescale 1ns / 1ps

module clh_queue_lock_unit #(
    parameter int THREADS = clhq_pkg::THREADS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [clhq_pkg::OP_W-1:0]      op,
    input  logic [clhq_pkg::THREAD_W-1:0]  thread,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [clhq_pkg::THREAD_W-1:0]  thread_echo,
    output logic                           granted
);

    import clhq_pkg::*;

    localparam int NODES = THREADS + 1;
    localparam int NW    = $clog2(NODES);
    localparam int TW    = $clog2(THREADS);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOOKUP = 5'b00010,
        S_NODE   = 5'b00100,
        S_PRED   = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [THREAD_W-1:0] thread_reg, thread_next;
    logic [NW-1:0]       node_reg, node_next;
    logic [NW-1:0]       pred_reg, pred_next;
    logic [NW-1:0]       tail_reg, tail_next;
    logic                granted_reg, granted_next;
    logic                out_valid_reg, out_valid_next;
    logic [THREAD_W-1:0] echo_reg, echo_next;
    logic                out_granted_reg, out_granted_next;

    logic                tn_rd_en;
    logic [TW-1:0]       tn_rd_addr;
    logic [NW-1:0]       tn_rd_node;
    logic                tn_wr_en;
    logic [TW-1:0]       tn_wr_addr;
    logic [NW-1:0]       tn_wr_node;

    logic                nm_rd_en;
    logic [NW-1:0]       nm_rd_addr;
    logic                nm_rd_done;
    logic [NW-1:0]       nm_rd_pred;
    logic                nm_wr_en;
    logic [NW-1:0]       nm_wr_addr;
    logic                nm_wr_done;
    logic [NW-1:0]       nm_wr_pred;

    logic                in_accept;
    logic                req_ok;
    logic [NW-1:0]       node_cur;
    logic [NW-1:0]       tail_ok;

    // Node numbers outside the table fall back to node zero.
    function automatic logic [NW-1:0] node_ok(input logic [NW-1:0] n);
        node_ok = (int'(n) < NODES) ? n : '0;
    endfunction

    clhq_thread_mem #(
        .THREADS (THREADS)
    ) u_thread_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (tn_rd_en),
        .rd_addr (tn_rd_addr),
        .rd_node (tn_rd_node),
        .wr_en   (tn_wr_en),
        .wr_addr (tn_wr_addr),
        .wr_node (tn_wr_node)
    );

    clhq_node_mem #(
        .THREADS (THREADS)
    ) u_node_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (nm_rd_en),
        .rd_addr (nm_rd_addr),
        .rd_done (nm_rd_done),
        .rd_pred (nm_rd_pred),
        .wr_en   (nm_wr_en),
        .wr_addr (nm_wr_addr),
        .wr_done (nm_wr_done),
        .wr_pred (nm_wr_pred)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign req_ok    = (int'(thread) < THREADS)
                       && ((op == OP_ACQUIRE) || (op == OP_RELEASE) || (op == OP_POLL));
    assign node_cur  = node_ok(tn_rd_node);
    assign tail_ok   = node_ok(tail_reg);

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        thread_next      = thread_reg;
        node_next        = node_reg;
        pred_next        = pred_reg;
        tail_next        = tail_reg;
        granted_next     = granted_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        echo_next        = echo_reg;
        out_granted_next = out_granted_reg;

        tn_rd_en   = 1'b0;
        tn_rd_addr = TW'(thread);
        tn_wr_en   = 1'b0;
        tn_wr_addr = TW'(thread_reg);
        tn_wr_node = node_ok(nm_rd_pred);

        nm_rd_en   = 1'b0;
        nm_rd_addr = node_cur;
        nm_wr_en   = 1'b0;
        nm_wr_addr = node_cur;
        nm_wr_done = 1'b0;
        nm_wr_pred = tail_ok;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    op_next      = op;
                    thread_next  = thread;
                    granted_next = 1'b0;
                    tn_rd_en     = req_ok;
                    state_next   = req_ok ? S_LOOKUP : S_EMIT;
                end
            end
            S_LOOKUP:
            begin
                node_next = node_cur;
                nm_rd_en  = 1'b1;
                if (op_reg == OP_ACQUIRE)
                begin
                    // Enqueue behind the old tail and fetch the tail's done flag.
                    nm_rd_addr = tail_ok;
                    nm_wr_en   = 1'b1;
                    nm_wr_addr = node_cur;
                    nm_wr_done = 1'b0;
                    nm_wr_pred = tail_ok;
                    pred_next  = tail_ok;
                    tail_next  = node_cur;
                end
                state_next = S_NODE;
            end
            S_NODE:
            begin
                case (op_reg)
                    OP_ACQUIRE:
                    begin
                        // A node queued behind itself sees the flag it just cleared.
                        granted_next = (pred_reg == node_reg) ? 1'b0 : nm_rd_done;
                        state_next   = S_EMIT;
                    end
                    OP_RELEASE:
                    begin
                        nm_wr_en     = 1'b1;
                        nm_wr_addr   = node_reg;
                        nm_wr_done   = 1'b1;
                        nm_wr_pred   = nm_rd_pred;
                        tn_wr_en     = 1'b1;
                        granted_next = 1'b0;
                        state_next   = S_EMIT;
                    end
                    default:
                    begin
                        nm_rd_en   = 1'b1;
                        nm_rd_addr = node_ok(nm_rd_pred);
                        state_next = S_PRED;
                    end
                endcase
            end
            S_PRED:
            begin
                granted_next = nm_rd_done;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    echo_next        = thread_reg;
                    out_granted_next = granted_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tail_reg      <= NW'(THREADS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        thread_reg      <= thread_next;
        node_reg        <= node_next;
        pred_reg        <= pred_next;
        granted_reg     <= granted_next;
        echo_reg        <= echo_next;
        out_granted_reg <= out_granted_next;
    end

    assign out_valid   = out_valid_reg;
    assign thread_echo = echo_reg;
    assign granted     = out_granted_reg;

    a_tail_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(tail_reg) < NODES)
        else $error("queue tail points outside the node table");

    a_node_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        nm_wr_en |-> ((state_reg == S_LOOKUP) && (op_reg == OP_ACQUIRE))
                  || ((state_reg == S_NODE) && (op_reg == OP_RELEASE)))
        else $error("node memory written outside acquire or release");

    a_thread_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        tn_wr_en |-> (state_reg == S_NODE) && (op_reg == OP_RELEASE))
        else $error("thread table written outside release");

    a_bad_req_skips: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !req_ok) |=> (state_reg == S_EMIT))
        else $error("unused request went through the memories");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !$past(out_valid)) |-> $past(state_reg == S_EMIT))
        else $error("result raised without passing the emit state");

endmodule

/* dv/clh_queue_lock_checker.sv */
`timescale 1ns / 1ps

module clh_queue_lock_checker #(
    parameter int THREADS = clhq_pkg::THREADS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [clhq_pkg::OP_W-1:0]     op,
    input  logic [clhq_pkg::THREAD_W-1:0] thread,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [clhq_pkg::THREAD_W-1:0] thread_echo,
    input  logic                          granted,
    output int                            errors,
    output int                            pending
);

    import clhq_pkg::*;

    localparam int NODES  = THREADS + 1;
    localparam int NODE_W = $clog2(NODES);

    typedef struct packed {
        logic [THREAD_W-1:0] thread;
        logic                granted;
    } lock_reply_t;

    // Shadow copy of the queue lock: one node per thread plus the dummy node.
    logic              node_done  [NODES];
    logic [NODE_W-1:0] node_pred  [NODES];
    logic [NODE_W-1:0] owned_node [THREADS];
    logic [NODE_W-1:0] tail_node;

    lock_reply_t reply_q [$];

    function automatic logic [NODE_W-1:0] clamp_node(input logic [NODE_W-1:0] n);
        return (int'(n) < NODES) ? n : '0;
    endfunction

    function automatic lock_reply_t apply_lock_op(input logic [OP_W-1:0] code,
                                                  input logic [THREAD_W-1:0] t);
        lock_reply_t       reply;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] pred;
        reply.thread  = t;
        reply.granted = 1'b0;
        if (int'(t) < THREADS)
        begin
            node = clamp_node(owned_node[t]);
            case (code)
                OP_ACQUIRE:
                begin
                    pred            = clamp_node(tail_node);
                    node_done[node] = 1'b0;
                    node_pred[node] = pred;
                    tail_node       = node;
                    // A node queued behind itself reads its own cleared flag here.
                    reply.granted   = node_done[pred];
                end
                OP_RELEASE:
                begin
                    pred            = clamp_node(node_pred[node]);
                    node_done[node] = 1'b1;
                    owned_node[t]   = pred;
                end
                OP_POLL:
                begin
                    reply.granted = node_done[clamp_node(node_pred[node])];
                end
                default:
                begin
                end
            endcase
        end
        return reply;
    endfunction

    task automatic flag_fault(input string msg);
        errors++;
        if (errors <= 10)
        begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        lock_reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                node_done[i] = 1'b1;
                node_pred[i] = '0;
            end
            for (int i = 0; i < THREADS; i++)
            begin
                owned_node[i] = NODE_W'(i);
            end
            tail_node = NODE_W'(THREADS);
            reply_q.delete();
        end
        else
        begin
            // Results leave before the item taken at the same edge can produce one.
            if (out_valid && out_ready)
            begin
                if (reply_q.size() == 0)
                begin
                    flag_fault($sformatf("unexpected result thread_echo=%0d granted=%0b",
                                         thread_echo, granted));
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (thread_echo !== want.thread || granted !== want.granted)
                    begin
                        flag_fault($sformatf(
                            "result mismatch: thread_echo %0d/%0d granted %0b/%0b (exp/got)",
                            want.thread, thread_echo, want.granted, granted));
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                reply_q.push_back(apply_lock_op(op, thread));
            end
        end
        pending = reply_q.size();
    end

endmodule

/* dv/clh_queue_lock_unit_test.sv */
`timescale 1ns / 1ps

module clh_queue_lock_unit_test;
    import clhq_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int THREAD_COUNT      = 64;
    // The directed part leaves this thread as its own predecessor, so the
    // well-formed traffic never has it acquire.
    localparam int BROKEN_THREAD     = 7;
    localparam int WELL_FORMED_ITEMS = 380;
    localparam int NOISE_ITEMS       = 50;
    localparam int CYCLE_LIMIT       = 200000;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic [OP_W-1:0]     op        = '0;
    logic [THREAD_W-1:0] thread    = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [THREAD_W-1:0] thread_echo;
    logic                granted;

    int errors;
    int pending;
    int accepted      = 0;
    int cycle_count   = 0;
    int stall_left    = 0;
    bit pressure_done = 1'b0;

    // Threads waiting for or holding the lock, in acquire order.
    int lock_line [$];
    bit in_line [THREAD_COUNT];

    clh_queue_lock_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .thread      (thread),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .thread_echo (thread_echo),
        .granted     (granted)
    );

    clh_queue_lock_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .thread      (thread),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .thread_echo (thread_echo),
        .granted     (granted),
        .errors      (errors),
        .pending     (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL clh_queue_lock_unit");
            $finish;
        end
    end

    function automatic bit quiet_stretch();
        return accepted >= 200 && accepted < 260;
    endfunction

    always @(posedge clk)
    begin : sink_pace
        int roll;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!pressure_done && accepted >= 120)
        begin
            // Long hold-off so the block backs up and refuses new items.
            pressure_done <= 1'b1;
            stall_left    <= 300;
            out_ready     <= 1'b0;
        end
        else if (quiet_stretch())
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready  <= 1'b0;
                stall_left <= (roll < 97) ? $urandom_range(0, 3) : $urandom_range(10, 40);
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet_stretch() || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    task automatic send_item(input logic [OP_W-1:0] code, input int t);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= code;
        thread   <= THREAD_W'(t);
        do
            @(posedge clk);
        while (!in_ready);
        accepted <= accepted + 1;
    endtask

    // One step of orderly lock traffic: idle threads join the queue, queued threads poll,
    // only the head of the queue releases, and now and then an item carries an unused op or polls from an idle thread.
    task automatic lock_traffic_step(input int depth_cap);
        int roll;
        int t;
        roll = $urandom_range(0, 99);
        if (lock_line.size() == 0 || (roll < 35 && lock_line.size() < depth_cap))
        begin
            do
                t = $urandom_range(0, THREAD_COUNT - 1);
            while (in_line[t] || t == BROKEN_THREAD);
            in_line[t] = 1'b1;
            lock_line.push_back(t);
            send_item(OP_ACQUIRE, t);
        end
        else if (roll < 60)
        begin
            t = lock_line.pop_front();
            in_line[t] = 1'b0;
            send_item(OP_RELEASE, t);
        end
        else if (roll < 94)
        begin
            send_item(OP_POLL, lock_line[$urandom_range(0, lock_line.size() - 1)]);
        end
        else if (roll < 97)
        begin
            send_item(OP_UNUSED, $urandom_range(0, THREAD_COUNT - 1));
        end
        else
        begin
            do
                t = $urandom_range(0, THREAD_COUNT - 1);
            while (in_line[t]);
            send_item(OP_POLL, t);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Release with no acquire before it: thread 0 takes back node 0.
        send_item(OP_RELEASE, 0);
        // Poll from a thread that never queued.
        send_item(OP_POLL, 5);
        send_item(OP_UNUSED, THREAD_COUNT - 1);
        send_item(OP_UNUSED, 0);
        // Two threads contend, then hand the lock over.
        send_item(OP_ACQUIRE, 0);
        send_item(OP_ACQUIRE, THREAD_COUNT - 1);
        send_item(OP_POLL, THREAD_COUNT - 1);
        send_item(OP_POLL, 0);
        send_item(OP_RELEASE, 0);
        send_item(OP_POLL, THREAD_COUNT - 1);
        send_item(OP_ACQUIRE, 0);
        send_item(OP_RELEASE, THREAD_COUNT - 1);
        send_item(OP_POLL, 0);
        send_item(OP_RELEASE, 0);
        // Repeated acquire: the node ends up queued behind itself.
        send_item(OP_ACQUIRE, BROKEN_THREAD);
        send_item(OP_ACQUIRE, BROKEN_THREAD);
        send_item(OP_POLL, BROKEN_THREAD);
        send_item(OP_RELEASE, BROKEN_THREAD);

        for (int i = 0; i < WELL_FORMED_ITEMS; i++)
        begin
            lock_traffic_step((i < 200) ? 4 : 12);
        end

        // Arbitrary traffic last, since misuse can leave nodes shared.
        repeat (NOISE_ITEMS)
        begin
            send_item(OP_W'($urandom_range(0, 3)), $urandom_range(0, THREAD_COUNT - 1));
        end

        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (10) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("PASS clh_queue_lock_unit");
        end
        else
        begin
            $display("FAIL clh_queue_lock_unit");
        end
        $finish;
    end

endmodule
